### rtl/core/i2c_master_bit_engine_top_assert.svh
// Assertion macros shared by the I2C master bit engine RTL.
// Checks compile away when SYNTHESIS is defined; needs clk and rst_n in scope.
`ifndef I2C_MASTER_BIT_ENGINE_TOP_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define I2CM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define I2CM_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define I2CM_ASSERT(lbl, prop, msg)
`define I2CM_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

### rtl/core/i2cm_pkg.sv
// Shared types and constants for the I2C master bit engine.
// No dependencies; used by the channel interfaces and the top level.
package i2cm_pkg;

    // command codes carried in the mode field
    localparam logic [2:0] CMD_IDLE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_STOP    = 3'd2;
    localparam logic [2:0] CMD_WRITE   = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;
    localparam logic [2:0] CMD_ACK     = 3'd5;
    localparam logic [2:0] CMD_NACK    = 3'd6;
    localparam logic [2:0] CMD_WAITACK = 3'd7;

    // configuration register indexes
    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_ACK_WAIT    = 1'b1;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd50;
    localparam logic [7:0]  ACK_WAIT_RST    = 8'd255;

    localparam logic [3:0] BYTE_BITS = 4'd8;
    localparam logic [3:0] LAST_BIT  = 4'd7;
    localparam logic [1:0] POLL_STEP = 2'd2;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       sda_in;
    } in_word_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_received;
        logic       ack_timeout;
    } out_word_t;

    typedef struct packed {
        logic        index;
        logic [15:0] value;
    } cfg_word_t;

endpackage

### rtl/core/i2cm_intf.sv
// Valid/ready channel interfaces for the I2C master bit engine.
// Depends on i2cm_pkg for the word types.
interface i2cm_in_if;
    import i2cm_pkg::*;
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface i2cm_out_if;
    import i2cm_pkg::*;
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface i2cm_cfg_if;
    import i2cm_pkg::*;
    logic      valid;
    logic      ready;
    cfg_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/i2c_master_bit_engine_top.sv
// I2C master bit engine: tick-driven SCL/SDA sequencer with result register.
// Depends on i2cm_pkg, the channel interfaces and the assertion macro header.
//
//  channel | dir | word        | meaning
//  --------+-----+-------------+-------------------------------------------
//  in_ch   | in  | in_word_t   | one tick: mode, tx_byte, sampled sda_in
//  out_ch  | out | out_word_t  | line drives and status after that tick
//  cfg_ch  | in  | cfg_word_t  | register write: 0 half period, 1 ack wait
//
// One word per clock while the sink keeps taking results: the sequencer state steps
// once per accepted tick and the result lands in the output register in the next cycle.
// in_ch.ready is high whenever the output register is empty or being taken,
// so a stalled sink holds back only the next tick, never the one in flight.
// cfg_ch.ready is always high; a write takes effect from the next tick.
// Reset: lines released, idle, half period 50, ack wait 255, flags cleared.

`include "i2c_master_bit_engine_top_assert.svh"

module i2c_master_bit_engine_top (
    input  logic       clk,
    input  logic       rst_n,
    i2cm_in_if.sink    in_ch,
    i2cm_out_if.source out_ch,
    i2cm_cfg_if.sink   cfg_ch
);
    import i2cm_pkg::*;

    // configuration
    logic [15:0] half_reg;
    logic [7:0]  ackw_reg;

    // sequencer state
    logic [2:0]  cmd_reg,   cmd_next;
    logic [1:0]  step_reg,  step_next;
    logic [3:0]  bit_reg,   bit_next;
    logic [15:0] ticks_reg, ticks_next;
    logic [7:0]  poll_reg,  poll_next;
    logic [7:0]  shift_reg, shift_next;
    logic        scl_reg,   scl_next;
    logic        sda_reg,   sda_next;
    logic [1:0]  ack_reg,   ack_next;
    logic [7:0]  rx_reg,    rx_next;

    // result register
    logic        out_valid_reg;
    out_word_t   out_data_reg, out_data_next;

    logic        in_acc;
    logic        busy_now;
    logic        done_now;
    logic [15:0] hold;
    logic [7:0]  limit;

    assign in_ch.ready   = !out_valid_reg || out_ch.ready;
    assign in_acc        = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready  = 1'b1;
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.data   = out_data_reg;

    // zero registers behave as one
    assign hold  = (half_reg == 16'd0) ? 16'd1 : half_reg;
    assign limit = (ackw_reg == 8'd0) ? 8'd1 : ackw_reg;

    always_comb
    begin
        logic        start;
        logic        adv;
        logic        fin;
        logic [16:0] ticks_inc;
        logic [7:0]  poll_inc;

        start     = (cmd_reg == CMD_IDLE) && (in_ch.data.mode != CMD_IDLE);
        adv       = 1'b0;
        fin       = 1'b0;
        busy_now  = 1'b0;
        done_now  = 1'b0;
        ticks_inc = 17'd0;
        poll_inc  = 8'd0;

        cmd_next   = cmd_reg;
        step_next  = step_reg;
        bit_next   = bit_reg;
        ticks_next = ticks_reg;
        poll_next  = poll_reg;
        shift_next = shift_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        rx_next    = rx_reg;

        // command launch, only from idle
        if (start)
        begin
            cmd_next   = in_ch.data.mode;
            step_next  = 2'd0;
            bit_next   = 4'd0;
            ticks_next = 16'd0;
            poll_next  = 8'd0;
            if (in_ch.data.mode == CMD_WRITE)
            begin
                shift_next = in_ch.data.tx_byte;
            end
            else if (in_ch.data.mode == CMD_READ)
            begin
                shift_next = 8'd0;
            end
            if (in_ch.data.mode == CMD_WAITACK)
            begin
                ack_next = 2'b00;
            end
        end

        if (cmd_next != CMD_IDLE)
        begin
            busy_now = 1'b1;
            if ((cmd_next == CMD_WAITACK) && (step_next == POLL_STEP))
            begin
                // untimed poll for a low acknowledge
                if (!in_ch.data.sda_in)
                begin
                    ack_next = 2'b01;
                    adv      = 1'b1;
                end
                else
                begin
                    poll_inc  = poll_next + 8'd1;
                    poll_next = poll_inc;
                    if (poll_inc >= limit)
                    begin
                        ack_next = 2'b10;
                        adv      = 1'b1;
                    end
                end
            end
            else
            begin
                // line drives change on the first tick of each phase
                if (ticks_next == 16'd0)
                begin
                    case (cmd_next)
                        CMD_START:
                        begin
                            if (step_next == 2'd0)      sda_next = 1'b1;
                            else if (step_next == 2'd1) scl_next = 1'b1;
                            else                        sda_next = 1'b0;
                        end
                        CMD_STOP:
                        begin
                            if (step_next == 2'd0)      sda_next = 1'b0;
                            else if (step_next == 2'd1) scl_next = 1'b1;
                            else                        sda_next = 1'b1;
                        end
                        CMD_ACK:
                        begin
                            if (step_next == 2'd0)
                            begin
                                scl_next = 1'b0;
                                sda_next = 1'b0;
                            end
                            else if (step_next == 2'd1)
                            begin
                                scl_next = 1'b1;
                            end
                            else
                            begin
                                scl_next = 1'b0;
                                sda_next = 1'b1;
                            end
                        end
                        CMD_NACK:
                        begin
                            if (step_next == 2'd0)
                            begin
                                scl_next = 1'b0;
                                sda_next = 1'b1;
                            end
                            else if (step_next == 2'd1)
                            begin
                                scl_next = 1'b1;
                            end
                            else
                            begin
                                scl_next = 1'b0;
                            end
                        end
                        CMD_WRITE:
                        begin
                            if (bit_next < BYTE_BITS)
                            begin
                                if (step_next == 2'd0)
                                    scl_next = 1'b0;
                                else if (step_next == 2'd1)
                                    sda_next = shift_next[3'd7 - bit_next[2:0]];
                                else
                                    scl_next = 1'b1;
                            end
                            else
                            begin
                                // release SDA for the slave acknowledge
                                if (step_next == 2'd0) scl_next = 1'b0;
                                else                   sda_next = 1'b1;
                            end
                        end
                        CMD_READ:
                        begin
                            if (step_next == 2'd0)
                            begin
                                scl_next = 1'b0;
                            end
                            else if (step_next == 2'd1)
                            begin
                                sda_next = 1'b1;
                                scl_next = 1'b1;
                            end
                            else
                            begin
                                scl_next = 1'b0;
                            end
                        end
                        CMD_WAITACK:
                        begin
                            if (step_next == 2'd0)      sda_next = 1'b1;
                            else if (step_next == 2'd1) scl_next = 1'b1;
                            else if (step_next == 2'd3) scl_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ticks_inc  = {1'b0, ticks_next} + 17'd1;
                ticks_next = ticks_inc[15:0];
                adv        = (ticks_inc >= {1'b0, hold});
            end

            // phase advance
            if (adv)
            begin
                ticks_next = 16'd0;
                case (cmd_next)
                    CMD_START, CMD_STOP, CMD_ACK, CMD_NACK:
                    begin
                        if (step_next >= 2'd2) fin = 1'b1;
                        else                   step_next = step_next + 2'd1;
                    end
                    CMD_WRITE:
                    begin
                        if (bit_next < BYTE_BITS)
                        begin
                            if (step_next >= 2'd2)
                            begin
                                bit_next  = bit_next + 4'd1;
                                step_next = 2'd0;
                            end
                            else
                            begin
                                step_next = step_next + 2'd1;
                            end
                        end
                        else if (step_next >= 2'd1)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            step_next = step_next + 2'd1;
                        end
                    end
                    CMD_READ:
                    begin
                        if (step_next == 2'd0)
                        begin
                            step_next = 2'd1;
                        end
                        else if (step_next == 2'd1)
                        begin
                            // sample at the end of the SCL high phase
                            shift_next = {shift_next[6:0], in_ch.data.sda_in};
                            step_next  = 2'd2;
                        end
                        else if (bit_next >= LAST_BIT)
                        begin
                            rx_next = shift_next;
                            fin     = 1'b1;
                        end
                        else
                        begin
                            bit_next  = bit_next + 4'd1;
                            step_next = 2'd1;
                        end
                    end
                    CMD_WAITACK:
                    begin
                        if (step_next == 2'd0)
                        begin
                            step_next = 2'd1;
                        end
                        else if (step_next == 2'd1)
                        begin
                            step_next = POLL_STEP;
                            poll_next = 8'd0;
                        end
                        else if (step_next == POLL_STEP)
                        begin
                            step_next = 2'd3;
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end

            if (fin)
            begin
                done_now   = 1'b1;
                cmd_next   = CMD_IDLE;
                step_next  = 2'd0;
                bit_next   = 4'd0;
                ticks_next = 16'd0;
            end
        end

        out_data_next.scl_out      = scl_next;
        out_data_next.sda_out      = sda_next;
        out_data_next.busy_res     = busy_now;
        out_data_next.done_res     = done_now;
        out_data_next.rx_byte      = rx_next;
        out_data_next.ack_received = ack_next[0];
        out_data_next.ack_timeout  = ack_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg      <= HALF_PERIOD_RST;
            ackw_reg      <= ACK_WAIT_RST;
            cmd_reg       <= CMD_IDLE;
            step_reg      <= 2'd0;
            bit_reg       <= 4'd0;
            ticks_reg     <= 16'd0;
            poll_reg      <= 8'd0;
            shift_reg     <= 8'd0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ack_reg       <= 2'b00;
            rx_reg        <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.data.index)
                    REG_HALF_PERIOD: half_reg <= cfg_ch.data.value;
                    REG_ACK_WAIT:    ackw_reg <= cfg_ch.data.value[7:0];
                    default:         half_reg <= half_reg;
                endcase
            end
            if (in_acc)
            begin
                cmd_reg       <= cmd_next;
                step_reg      <= step_next;
                bit_reg       <= bit_next;
                ticks_reg     <= ticks_next;
                poll_reg      <= poll_next;
                shift_reg     <= shift_next;
                scl_reg       <= scl_next;
                sda_reg       <= sda_next;
                ack_reg       <= ack_next;
                rx_reg        <= rx_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            out_data_reg <= out_data_next;
        end
    end

    `I2CM_ASSERT(a_idle_clean, (cmd_reg == CMD_IDLE) |-> (step_reg == 2'd0 && bit_reg == 4'd0 && ticks_reg == 16'd0), "idle with live phase state")
    `I2CM_ASSERT(a_done_to_idle, (in_acc && done_now) |=> (cmd_reg == CMD_IDLE), "command did not retire on done")
    `I2CM_ASSERT_NEVER(a_bit_range, (bit_reg > BYTE_BITS), "bit index past byte end")
    `I2CM_ASSERT(a_ack_flags, $onehot0(ack_reg), "ack and timeout both set")

endmodule

### tb/tb.sv
// Self-checking testbench for the tick-driven I2C master bit engine.
// Needs i2cm_pkg, the i2cm channel interfaces and i2c_master_bit_engine_top.
// A line tracker predicts every result word and checks the DUT's output stream.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    // How SDA answers while a wait-ack is polling
    typedef enum {SDA_ANY, SDA_ACKS, SDA_NEVER} ack_style_t;

    // Tracks the bit engine's line sequencer and the result words it owes.
    class line_tracker_t;
        logic [15:0] half_period;
        logic [7:0]  ack_wait;
        logic [2:0]  cmd;
        logic [3:0]  phase;
        logic [3:0]  bit_no;
        logic [15:0] phase_ticks;
        logic [7:0]  polls;
        logic [7:0]  shreg;
        logic        scl;
        logic        sda;
        logic [1:0]  flags;
        logic [7:0]  rx_last;
        out_word_t   expected_line_words[$];
        int          errors;
        int          words_seen;

        function new();
            half_period = HALF_PERIOD_RST;
            ack_wait    = ACK_WAIT_RST;
            cmd         = CMD_IDLE;
            phase       = '0;
            bit_no      = '0;
            phase_ticks = '0;
            polls       = '0;
            shreg       = '0;
            scl         = 1'b1;
            sda         = 1'b1;
            flags       = '0;
            rx_last     = '0;
            errors      = 0;
            words_seen  = 0;
        endfunction

        function void write_reg(logic idx, logic [15:0] val);
            if (idx == REG_HALF_PERIOD)
                half_period = val;
            else
                ack_wait = val[7:0];
        endfunction

        function bit idle();
            return cmd == CMD_IDLE;
        endfunction

        function bit polling();
            return cmd == CMD_WAITACK && phase == POLL_STEP;
        endfunction

        function int pending();
            return expected_line_words.size();
        endfunction

        // line changes made on the first tick of a phase
        function void drive_phase_lines();
            case (cmd)
                CMD_START:
                    if (phase == 0) sda = 1'b1;
                    else if (phase == 1) scl = 1'b1;
                    else sda = 1'b0;
                CMD_STOP:
                    if (phase == 0) sda = 1'b0;
                    else if (phase == 1) scl = 1'b1;
                    else sda = 1'b1;
                CMD_ACK:
                    if (phase == 0) begin scl = 1'b0; sda = 1'b0; end
                    else if (phase == 1) scl = 1'b1;
                    else begin scl = 1'b0; sda = 1'b1; end
                CMD_NACK:
                    if (phase == 0) begin scl = 1'b0; sda = 1'b1; end
                    else if (phase == 1) scl = 1'b1;
                    else scl = 1'b0;
                CMD_WRITE:
                    if (bit_no < BYTE_BITS) begin
                        if (phase == 0) scl = 1'b0;
                        else if (phase == 1) sda = shreg[LAST_BIT - bit_no];
                        else scl = 1'b1;
                    end else begin
                        if (phase == 0) scl = 1'b0;
                        else sda = 1'b1;
                    end
                CMD_READ:
                    if (phase == 0) scl = 1'b0;
                    else if (phase == 1) begin sda = 1'b1; scl = 1'b1; end
                    else scl = 1'b0;
                CMD_WAITACK:
                    if (phase == 0) sda = 1'b1;
                    else if (phase == 1) scl = 1'b1;
                    else if (phase == POLL_STEP + 1) scl = 1'b0;
                default: ;
            endcase
        endfunction

        // step to the next phase; 1 when the command is complete
        function bit next_phase(logic sda_in);
            phase_ticks = '0;
            case (cmd)
                CMD_START, CMD_STOP, CMD_ACK, CMD_NACK: begin
                    if (phase >= 2) return 1'b1;
                    phase = phase + 4'd1;
                    return 1'b0;
                end
                CMD_WRITE: begin
                    if (bit_no < BYTE_BITS) begin
                        if (phase >= 2) begin
                            bit_no = bit_no + 4'd1;
                            phase  = 0;
                        end else begin
                            phase = phase + 4'd1;
                        end
                        return 1'b0;
                    end
                    if (phase >= 1) return 1'b1;
                    phase = phase + 4'd1;
                    return 1'b0;
                end
                CMD_READ: begin
                    if (phase == 0) begin
                        phase = 1;
                        return 1'b0;
                    end
                    if (phase == 1) begin
                        shreg = {shreg[6:0], sda_in};
                        phase = 2;
                        return 1'b0;
                    end
                    if (bit_no >= LAST_BIT) begin
                        rx_last = shreg;
                        return 1'b1;
                    end
                    bit_no = bit_no + 4'd1;
                    phase  = 1;
                    return 1'b0;
                end
                CMD_WAITACK: begin
                    if (phase == 0) begin
                        phase = 1;
                        return 1'b0;
                    end
                    if (phase == 1) begin
                        phase = {2'b00, POLL_STEP};
                        polls = '0;
                        return 1'b0;
                    end
                    if (phase == POLL_STEP) begin
                        phase = {2'b00, POLL_STEP} + 4'd1;
                        return 1'b0;
                    end
                    return 1'b1;
                end
                default: return 1'b1;
            endcase
        endfunction

        function out_word_t line_state_after_tick(in_word_t w);
            logic [15:0] hold;
            logic [7:0]  limit;
            logic        fin;
            out_word_t   r;
            hold  = (half_period == 0) ? 16'd1 : half_period;
            limit = (ack_wait == 0) ? 8'd1 : ack_wait;
            fin   = 1'b0;
            r     = '0;
            // mode only counts while nothing runs
            if (cmd == CMD_IDLE && w.mode != CMD_IDLE) begin
                cmd         = w.mode;
                phase       = '0;
                bit_no      = '0;
                phase_ticks = '0;
                polls       = '0;
                if (w.mode == CMD_WRITE) shreg = w.tx_byte;
                else if (w.mode == CMD_READ) shreg = '0;
                if (w.mode == CMD_WAITACK) flags = '0;
            end
            if (cmd != CMD_IDLE) begin
                r.busy_res = 1'b1;
                if (polling()) begin
                    if (!w.sda_in) begin
                        flags = 2'b01;
                        fin   = next_phase(w.sda_in);
                    end else begin
                        polls = polls + 8'd1;
                        if (polls >= limit) begin
                            flags = 2'b10;
                            fin   = next_phase(w.sda_in);
                        end
                    end
                end else begin
                    if (phase_ticks == 0) drive_phase_lines();
                    phase_ticks = phase_ticks + 16'd1;
                    if (phase_ticks >= hold) fin = next_phase(w.sda_in);
                end
                if (fin) begin
                    r.done_res  = 1'b1;
                    cmd         = CMD_IDLE;
                    phase       = '0;
                    bit_no      = '0;
                    phase_ticks = '0;
                end
            end
            r.scl_out      = scl;
            r.sda_out      = sda;
            r.rx_byte      = rx_last;
            r.ack_received = flags[0];
            r.ack_timeout  = flags[1];
            return r;
        endfunction

        function void note_tick(in_word_t w);
            expected_line_words.push_back(line_state_after_tick(w));
        endfunction

        task report_mismatch(string field, logic [7:0] got, logic [7:0] want);
            $display("word %0d: %s is %0h, expected %0h", words_seen, field, got, want);
            errors++;
        endtask

        task check_word(out_word_t got);
            out_word_t want;
            if (expected_line_words.size() == 0) begin
                report_mismatch("unexpected word, rx_byte", got.rx_byte, 8'h00);
                words_seen++;
                return;
            end
            want = expected_line_words.pop_front();
            if (got.scl_out !== want.scl_out)
                report_mismatch("scl_out", 8'(got.scl_out), 8'(want.scl_out));
            if (got.sda_out !== want.sda_out)
                report_mismatch("sda_out", 8'(got.sda_out), 8'(want.sda_out));
            if (got.busy_res !== want.busy_res)
                report_mismatch("busy_res", 8'(got.busy_res), 8'(want.busy_res));
            if (got.done_res !== want.done_res)
                report_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
            if (got.rx_byte !== want.rx_byte)
                report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
            if (got.ack_received !== want.ack_received)
                report_mismatch("ack_received", 8'(got.ack_received),
                                8'(want.ack_received));
            if (got.ack_timeout !== want.ack_timeout)
                report_mismatch("ack_timeout", 8'(got.ack_timeout),
                                8'(want.ack_timeout));
            words_seen++;
        endtask
    endclass

    // Generous bound on the run length in clock cycles, covering every tick and drain
    localparam int CYCLE_LIMIT = 300000;

    logic clk = 1'b0;
    logic rst_n;
    int   cycles = 0;
    int   ticks_sent = 0;
    bit   calm_tail = 1'b0;   // no idling on either side once set

    line_tracker_t tracker = new();

    i2cm_in_if  in_ch();
    i2cm_out_if out_ch();
    i2cm_cfg_if cfg_ch();

    i2c_master_bit_engine_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: hung handshake or lost result word
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result sink: random back-pressure bursts
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (!calm_tail && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Every result word taken by the sink goes to the tracker
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            tracker.check_word(out_ch.data);
    end

    // One tick word; waits for the handshake, then maybe idles a burst
    task automatic drive_tick(logic [2:0] mode, logic [7:0] tx, logic sda_in);
        in_word_t w;
        w.mode    = mode;
        w.tx_byte = tx;
        w.sda_in  = sda_in;
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge clk); while (!in_ch.ready);
        tracker.note_tick(w);
        ticks_sent++;
        if (!calm_tail && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every expected word is back
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // Register update after a drain: both registers, valid held across the pair
    task automatic set_timing(logic [15:0] hold, logic [7:0] ackw);
        cfg_word_t c;
        drain();
        c.index = REG_HALF_PERIOD;
        c.value = hold;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= c;
        do @(posedge clk); while (!cfg_ch.ready);
        tracker.write_reg(REG_HALF_PERIOD, hold);
        c.index = REG_ACK_WAIT;
        c.value = {8'h00, ackw};
        cfg_ch.data <= c;
        do @(posedge clk); while (!cfg_ch.ready);
        tracker.write_reg(REG_ACK_WAIT, {8'h00, ackw});
        cfg_ch.valid <= 1'b0;
    endtask

    // SDA level for the next tick; only the wait-ack poll phase is steered
    function automatic logic pick_sda(ack_style_t style);
        if (!tracker.polling())
            return 1'($urandom_range(0, 1));
        case (style)
            SDA_ACKS:  return $urandom_range(0, 2) != 0;
            SDA_NEVER: return 1'b1;
            default:   return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // Issue a command and keep ticking until it completes.
    // Ticks in between carry random modes, which must be ignored.
    task automatic run_command(logic [2:0] op, logic [7:0] tx, ack_style_t style);
        drive_tick(op, tx, 1'($urandom_range(0, 1)));
        while (!tracker.idle())
            drive_tick(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                       pick_sda(style));
    endtask

    initial
    begin
        logic [15:0] hold_set[5] = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd1};
        logic [7:0]  wait_set[5] = '{8'd1, 8'd3, 8'd0, 8'd255, 8'd6};
        logic [2:0]  op;
        int          stop_at;
        ack_style_t  style;

        rst_n        = 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset timing (50 ticks a phase): start a command, mode ignored meanwhile
        drive_tick(CMD_START, 8'h00, 1'b1);
        repeat (5) drive_tick(3'($urandom_range(1, 7)), 8'hFF, 1'b0);
        // Largest half period applied mid-command, then shrunk so it completes
        set_timing(16'hFFFF, 8'd255);
        repeat (3) drive_tick(CMD_IDLE, 8'h00, 1'b1);
        set_timing(16'd1, 8'd2);
        while (!tracker.idle())
            drive_tick(CMD_IDLE, 8'h00, 1'($urandom_range(0, 1)));

        // Write and wait-ack twice, then read, ack, nack and stop; byte extremes, ack seen and ack timeout
        run_command(CMD_WRITE, 8'hFF, SDA_ANY);
        run_command(CMD_WAITACK, 8'h00, SDA_ACKS);
        run_command(CMD_WRITE, 8'h00, SDA_ANY);
        run_command(CMD_WAITACK, 8'hFF, SDA_NEVER);
        run_command(CMD_READ, 8'h5A, SDA_ANY);
        run_command(CMD_ACK, 8'h00, SDA_ANY);
        run_command(CMD_NACK, 8'h00, SDA_ANY);
        run_command(CMD_STOP, 8'h00, SDA_ANY);
        drive_tick(CMD_IDLE, 8'hA5, 1'b0);

        // Zero registers behave as one
        set_timing(16'd0, 8'd0);
        run_command(CMD_WAITACK, 8'h00, SDA_NEVER);
        run_command(CMD_START, 8'h00, SDA_ANY);

        // Random traffic over several timing settings, last one with no idling
        for (int k = 0; k < 5; k++)
        begin
            set_timing(hold_set[k], wait_set[k]);
            if (k == 4)
                calm_tail = 1'b1;
            stop_at = ticks_sent + 75;
            while (ticks_sent < stop_at)
            begin
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3))
                        drive_tick(CMD_IDLE, 8'($urandom_range(0, 255)),
                                   1'($urandom_range(0, 1)));
                op = 3'($urandom_range(1, 7));
                case ($urandom_range(0, 3))
                    0:       style = SDA_NEVER;
                    1:       style = SDA_ANY;
                    default: style = SDA_ACKS;
                endcase
                run_command(op, 8'($urandom_range(0, 255)), style);
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

### i2c_master_bit_engine_top.f
+incdir+rtl/core
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_intf.sv
rtl/core/i2c_master_bit_engine_top.sv
tb/tb.sv
